/* design/b2b_pkg.sv */
// ----------------------------------------------------------------------------
// b2b_pkg: shared types, constants and helpers for the BLAKE2b engine
// Holds the IV, the message schedule and the state word permutations.
// ----------------------------------------------------------------------------
package b2b_pkg;

  typedef logic [63:0] word_t;
  typedef word_t [15:0] vstate_t;
  typedef word_t [7:0]  chain_t;

  typedef struct packed {
    logic start;
    logic last;
  } eng_ctrl_t;

  typedef enum logic [1:0] {
    ROT_COL    = 2'd0,
    ROT_DIAG   = 2'd1,
    ROT_UNDIAG = 2'd2
  } rot_mode_t;

  localparam chain_t IV = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b,
    64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
    64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
    64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  // Rounds 10 and 11 reuse the first two schedule rows.
  function automatic logic [3:0] sigma(input logic [3:0] rnd, input logic [3:0] idx);
    logic [3:0] row;
    row = (rnd >= 4'd10) ? rnd - 4'd10 : rnd;
    return SIGMA[row][idx];
  endfunction

  // The mixer always works on column zero. Rows are rotated after each
  // call so the next column or diagonal moves into that position.
  function automatic vstate_t rot_rows(input vstate_t v, input rot_mode_t m);
    vstate_t vo;
    int k;
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        case (m)
          ROT_DIAG: k = (j + 1 + r) % 4;
          ROT_UNDIAG: k = (j + 5 - r) % 4;
          default: k = (j + 1) % 4;
        endcase
        vo[r*4+j] = v[r*4+k];
      end
    end
    return vo;
  endfunction

  function automatic logic [6:0] eff_len(input logic [6:0] d);
    logic [6:0] e;
    if (d == 7'd0) e = 7'd1;
    else if (d > 7'd64) e = 7'd64;
    else e = d;
    return e;
  endfunction

  function automatic chain_t param_chain(input logic [6:0] d);
    chain_t c;
    c = IV;
    c[0] = c[0] ^ {57'd0, eff_len(d)} ^ 64'h0000_0000_0101_0000;
    return c;
  endfunction

endpackage

/* design/b2b_ram.sv */
// ----------------------------------------------------------------------------
// b2b_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data is registered and appears in the next cycle.
// ----------------------------------------------------------------------------
module b2b_ram #(
  parameter int Width = 64,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/b2b_mix.sv */
// ----------------------------------------------------------------------------
// b2b_mix: one quarter of the G function
// Even phases update a and d, odd phases update c and b.
// ----------------------------------------------------------------------------
module b2b_mix
  import b2b_pkg::*;
(
  input  logic [1:0] phase,
  input  word_t      a,
  input  word_t      b,
  input  word_t      c,
  input  word_t      d,
  input  word_t      x,
  output word_t      a_n,
  output word_t      b_n,
  output word_t      c_n,
  output word_t      d_n
);

  word_t sum_ab;
  word_t dx;
  word_t sum_cd;
  word_t bx;

  always_comb begin
    sum_ab = a + b + x;
    dx     = d ^ sum_ab;
    sum_cd = c + d;
    bx     = b ^ sum_cd;
    a_n = a;
    b_n = b;
    c_n = c;
    d_n = d;
    if (!phase[0]) begin
      a_n = sum_ab;
      d_n = phase[1] ? {dx[15:0], dx[63:16]} : {dx[31:0], dx[63:32]};
    end else begin
      c_n = sum_cd;
      b_n = phase[1] ? {bx[62:0], bx[63]} : {bx[23:0], bx[63:24]};
    end
  end

endmodule

/* design/b2b_round.sv */
// ----------------------------------------------------------------------------
// b2b_round: compression engine
// Runs 12 rounds of 8 G calls through one quarter-G mixer and fetches
// message words from the block RAM one step ahead.
// ----------------------------------------------------------------------------
module b2b_round
  import b2b_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  eng_ctrl_t ctrl,
  input  chain_t    chain_in,
  input  word_t     t_lo,
  input  word_t     t_hi,
  input  logic [4:0] valid_words,
  output logic [3:0] ram_raddr,
  input  word_t     ram_rdata,
  output logic      done,
  output chain_t    chain_out
);

  vstate_t    v_r;
  logic [3:0] rnd_r;
  logic [2:0] g_r;
  logic [1:0] ph_r;
  logic       busy_r;
  logic       done_r;
  logic [3:0] maddr_r;

  word_t   mword;
  word_t   a_n, b_n, c_n, d_n;
  vstate_t v_mix;
  rot_mode_t mode;

  // Words past the fill count belong to the zero padding.
  assign mword = ({1'b0, maddr_r} < valid_words) ? ram_rdata : '0;

  b2b_mix u_mix (
    .phase (ph_r),
    .a     (v_r[0]),
    .b     (v_r[4]),
    .c     (v_r[8]),
    .d     (v_r[12]),
    .x     (mword),
    .a_n   (a_n),
    .b_n   (b_n),
    .c_n   (c_n),
    .d_n   (d_n)
  );

  always_comb begin
    v_mix     = v_r;
    v_mix[0]  = a_n;
    v_mix[4]  = b_n;
    v_mix[8]  = c_n;
    v_mix[12] = d_n;
    if (g_r == 3'd3) mode = ROT_DIAG;
    else if (g_r == 3'd7) mode = ROT_UNDIAG;
    else mode = ROT_COL;
  end

  always_comb begin
    if (ctrl.start) ram_raddr = sigma(4'd0, 4'd0);
    else if (!ph_r[1]) ram_raddr = sigma(rnd_r, {g_r, 1'b1});
    else if (g_r == 3'd7) ram_raddr = sigma(rnd_r + 4'd1, 4'd0);
    else ram_raddr = sigma(rnd_r, {g_r + 3'd1, 1'b0});
  end

  always_ff @(posedge clk) begin
    maddr_r <= ram_raddr;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
      g_r    <= '0;
      ph_r   <= '0;
    end else if (ctrl.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      rnd_r  <= '0;
      g_r    <= '0;
      ph_r   <= '0;
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= chain_in[i];
      end
      for (int i = 0; i < 4; i++) begin
        v_r[i+8] <= IV[i];
      end
      v_r[12] <= IV[4] ^ t_lo;
      v_r[13] <= IV[5] ^ t_hi;
      v_r[14] <= ctrl.last ? ~IV[6] : IV[6];
      v_r[15] <= IV[7];
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          v_r <= rot_rows(v_mix, mode);
          g_r <= g_r + 3'd1;
          if (g_r == 3'd7) begin
            rnd_r <= rnd_r + 4'd1;
            if (rnd_r == 4'd11) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end else begin
          v_r <= v_mix;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) chain_out[i] = chain_in[i] ^ v_r[i] ^ v_r[i+8];
  end

  assign done = done_r;

endmodule

/* design/blake2b_hash.sv */
// ----------------------------------------------------------------------------
// blake2b_hash: unkeyed BLAKE2b hash engine
// Word-serial message input, digest output of up to eight words.
// ----------------------------------------------------------------------------
// Message words enter on the in_ channel, first byte in bits 7:0. A word
// that does not start a new block passes S_STORE before in_ready returns. A
// word that follows a full block first waits for that block's compression:
// a start, 12 rounds of 8 G calls on the single shared mixer and a hand-back.
// The final word pads the block and compresses it the same way; the digest
// leaves on the out_ channel as ceil(eff/8) requests, eff being digest_bytes
// clamped to 1..64, one per cycle while out_ready is high. A stall on
// out_ready holds the current digest word; no input is taken until the last
// digest word is gone. The engine then reloads the chaining value for the
// next message. Reset sets digest_bytes to 32 and clears the byte counter
// and fill count. A write on cfg_ sets the digest length and restarts the
// message; the user must write cfg_ only while idle, as nothing enforces it.
// ----------------------------------------------------------------------------
module blake2b_hash
  import b2b_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_final_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_word,
  output logic [3:0]  out_digest_valid_bytes,
  output logic        out_digest_last,
  input  logic        cfg_write_en,
  input  logic [6:0]  cfg_digest_bytes
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_STORE = 4'b0010,
    S_COMP  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t     state_r;
  logic [4:0] held_r;
  word_t      t_lo_r, t_hi_r;
  chain_t     chain_r;
  logic [6:0] digest_r;
  word_t      pend_word_r;
  logic [3:0] pend_bc_r;
  logic       pend_fin_r;
  logic       last_r;
  logic [4:0] vw_r;
  logic       start_r;
  logic [2:0] oidx_r;

  logic       in_acc;
  logic       out_acc;
  logic [3:0] bc_eff;
  word_t      w_masked;
  logic [7:0] buf_bytes;
  logic [7:0] add_n;
  logic       do_add;
  word_t      lo_sum;
  logic [6:0] eff;
  logic [3:0] nout;
  logic [6:0] rem;

  logic       eng_done;
  chain_t     eng_chain;
  logic [3:0] ram_raddr;
  word_t      ram_rdata;
  eng_ctrl_t  eng_ctrl;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_acc   = out_valid && out_ready;

  always_comb begin
    if (!in_final_word || in_byte_count > 4'd8) bc_eff = 4'd8;
    else bc_eff = in_byte_count;
    for (int i = 0; i < 8; i++) begin
      w_masked[i*8 +: 8] = (4'(i) < bc_eff) ? in_data_word[i*8 +: 8] : 8'h00;
    end
  end

  // Byte count of the final block; the pending word is not yet in held_r.
  assign buf_bytes = {held_r, 3'b000} + ((pend_bc_r != 4'd0) ? {4'd0, pend_bc_r} : 8'd0);

  always_comb begin
    do_add = 1'b0;
    add_n  = 8'd128;
    if (in_acc && bc_eff != 4'd0 && held_r == 5'd16) begin
      do_add = 1'b1;
    end else if (state_r == S_STORE && pend_fin_r) begin
      do_add = 1'b1;
      add_n  = buf_bytes;
    end
    lo_sum = t_lo_r + {56'd0, add_n};
  end

  assign eng_ctrl = '{start: start_r, last: last_r};

  b2b_ram #(.Width(64), .Depth(16)) u_ram (
    .clk   (clk),
    .we    (state_r == S_STORE && pend_bc_r != 4'd0),
    .waddr (held_r[3:0]),
    .wdata (pend_word_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  b2b_round u_round (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (eng_ctrl),
    .chain_in    (chain_r),
    .t_lo        (t_lo_r),
    .t_hi        (t_hi_r),
    .valid_words (vw_r),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .done        (eng_done),
    .chain_out   (eng_chain)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      held_r   <= '0;
      t_lo_r   <= '0;
      t_hi_r   <= '0;
      digest_r <= 7'd32;
      chain_r  <= param_chain(7'd32);
      start_r  <= 1'b0;
      last_r   <= 1'b0;
      vw_r     <= '0;
      oidx_r   <= '0;
    end else if (cfg_write_en) begin
      state_r  <= S_IDLE;
      held_r   <= '0;
      t_lo_r   <= '0;
      t_hi_r   <= '0;
      digest_r <= cfg_digest_bytes;
      chain_r  <= param_chain(cfg_digest_bytes);
      start_r  <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (do_add) begin
        t_lo_r <= lo_sum;
        if (lo_sum < t_lo_r) t_hi_r <= t_hi_r + 64'd1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            pend_word_r <= w_masked;
            pend_bc_r   <= bc_eff;
            pend_fin_r  <= in_final_word;
            if (bc_eff != 4'd0 && held_r == 5'd16) begin
              last_r  <= 1'b0;
              vw_r    <= 5'd16;
              start_r <= 1'b1;
              state_r <= S_COMP;
            end else begin
              state_r <= S_STORE;
            end
          end
        end
        S_STORE: begin
          if (pend_bc_r != 4'd0) held_r <= held_r + 5'd1;
          if (pend_fin_r) begin
            last_r  <= 1'b1;
            vw_r    <= held_r + ((pend_bc_r != 4'd0) ? 5'd1 : 5'd0);
            start_r <= 1'b1;
            state_r <= S_COMP;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_COMP: begin
          if (eng_done) begin
            chain_r <= eng_chain;
            if (last_r) begin
              oidx_r  <= '0;
              state_r <= S_OUT;
            end else begin
              held_r  <= '0;
              state_r <= S_STORE;
            end
          end
        end
        S_OUT: begin
          if (out_acc) begin
            oidx_r <= oidx_r + 3'd1;
            if (out_digest_last) begin
              chain_r <= param_chain(digest_r);
              t_lo_r  <= '0;
              t_hi_r  <= '0;
              held_r  <= '0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    eff  = eff_len(digest_r);
    nout = 4'((eff + 7'd7) >> 3);
    rem  = eff - {1'b0, oidx_r, 3'b000};
    out_digest_word        = chain_r[oidx_r];
    out_digest_valid_bytes = (rem > 7'd8) ? 4'd8 : rem[3:0];
    out_digest_last        = ({1'b0, oidx_r} + 4'd1 == nout);
  end

endmodule

/* design/b2b_checker.sv */
// ----------------------------------------------------------------------------
// b2b_checker: port-level checks for blake2b_hash
// Watches the request channels and the digest burst.
// ----------------------------------------------------------------------------
module b2b_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_digest_word,
  input logic [3:0]  out_digest_valid_bytes,
  input logic        out_digest_last,
  input logic        cfg_write_en
);

  // No message word is taken while a digest is being delivered.
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while digest pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !cfg_write_en |=>
      out_valid && $stable(out_digest_word) && $stable(out_digest_last))
    else $error("stalled digest request changed");

  a_bytes_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digest_valid_bytes >= 4'd1 && out_digest_valid_bytes <= 4'd8)
    else $error("digest byte count out of range");

  // Digest words go out as one unbroken burst ending with the last flag.
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_digest_last && !cfg_write_en |=> out_valid)
    else $error("gap inside digest burst");

  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_digest_last |=> !out_valid)
    else $error("digest request after last word");

endmodule

bind blake2b_hash b2b_checker u_b2b_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_ready               (in_ready),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_digest_word        (out_digest_word),
  .out_digest_valid_bytes (out_digest_valid_bytes),
  .out_digest_last        (out_digest_last),
  .cfg_write_en           (cfg_write_en)
);
